@@ sv/uint64_to_ascii_padded_macros.svh @@
// Assertion macros shared by the uint64_to_ascii_padded RTL.
// Depends on a clock named clk and a reset named rst in the using scope.
`ifndef UINT64_TO_ASCII_PADDED_MACROS_SVH
`define UINT64_TO_ASCII_PADDED_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset
`define UIA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("uia assertion failed");
// Next-cycle implication, disabled during reset
`define UIA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("uia assertion failed");
`else
`define UIA_ASSERT_NOW(label, ante, cons)
`define UIA_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ sv/uia_pkg.sv @@
// Package for uint64_to_ascii_padded: widths, codes, handoff struct, char lookup.
// No dependencies.
package uia_pkg;

  localparam int VALUE_W  = 64;
  localparam int DIGITS   = 20;
  localparam int BCD_W    = DIGITS * 4;
  localparam int BIT_W    = $clog2(VALUE_W);
  localparam int NDIG_W   = $clog2(DIGITS + 1);
  localparam int WIDTH_W  = 6;
  localparam int OUT_CAP  = 39;
  localparam int SENT_W   = $clog2(OUT_CAP + 1);
  localparam int HEX_DIGS = VALUE_W / 4;

  // Radix selector codes; the unused code behaves as upper-case hex
  localparam logic [1:0] RADIX_DEC   = 2'd0;
  localparam logic [1:0] RADIX_LOWER = 2'd1;
  localparam logic [1:0] RADIX_UPPER = 2'd2;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_UA    = 8'h41;

  // Converted number handed from the converter to the emitter
  typedef struct packed {
    logic [BCD_W-1:0]   digits;    // most significant digit at the top nibble
    logic [NDIG_W-1:0]  ndig;      // digit count, 1..DIGITS
    logic [1:0]         radix_mode;
    logic               zero_pad;
    logic [WIDTH_W-1:0] min_width;
  } conv_res_t;

  // One digit value to its ASCII character
  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic lower);
    logic [7:0] base;
    base = lower ? CH_LA : CH_UA;
    if (d < 4'd10) return CH_ZERO + {4'b0, d};
    else return base + {4'b0, d} - 8'd10;
  endfunction

endpackage

@@ sv/uia_if.sv @@
// Channel interfaces for uint64_to_ascii_padded: number input and character output.
// Depends on uia_pkg.
interface uia_in_if
  import uia_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  logic [1:0]         radix_mode;
  logic               zero_pad;
  logic [WIDTH_W-1:0] min_width;

  modport source (output valid, value, radix_mode, zero_pad, min_width, input ready);
  modport sink   (input valid, value, radix_mode, zero_pad, min_width, output ready);
endinterface

interface uia_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last_char;

  modport source (output valid, out_char, last_char, input ready);
  modport sink   (input valid, out_char, last_char, output ready);
endinterface

@@ sv/uia_conv.sv @@
// Bit-serial converter: shift-and-add-3 binary to BCD, or nibble load for hex,
// then leading-zero strip one digit per cycle. Depends on uia_pkg, uia_if, macros.
`include "uint64_to_ascii_padded_macros.svh"

module uia_conv
  import uia_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  uia_in_if.sink      num,
  output logic        res_valid,
  input  logic        res_ready,
  output conv_res_t   res
);

  typedef enum logic [3:0] {
    C_IDLE = 4'b0001,
    C_DAB  = 4'b0010,
    C_NORM = 4'b0100,
    C_DONE = 4'b1000
  } conv_state_t;

  conv_state_t        state, state_next;
  logic [VALUE_W-1:0] bin;
  logic [BCD_W-1:0]   bcd;
  logic [BCD_W-1:0]   bcd_adj;
  logic [BIT_W-1:0]   bitcnt;
  logic [NDIG_W-1:0]  ndig;
  logic [1:0]         rmode;
  logic               zpad;
  logic [WIDTH_W-1:0] width;
  logic               take;
  logic               strip;

  assign num.ready = (state == C_IDLE);
  assign take      = num.valid && num.ready;
  assign strip     = (bcd[BCD_W-1 -: 4] == 4'd0) && (ndig > NDIG_W'(1));

  // Add 3 to every BCD digit of 5 or more ahead of the shift
  always_comb begin
    logic [3:0] dig;
    for (int i = 0; i < DIGITS; i++) begin
      dig = bcd[i*4 +: 4];
      bcd_adj[i*4 +: 4] = (dig >= 4'd5) ? dig + 4'd3 : dig;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      C_IDLE: if (take) state_next = (num.radix_mode == RADIX_DEC) ? C_DAB : C_NORM;
      C_DAB:  if (bitcnt == BIT_W'(VALUE_W - 1)) state_next = C_NORM;
      C_NORM: if (!strip) state_next = C_DONE;
      C_DONE: if (res_ready) state_next = C_IDLE;
      default: state_next = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= C_IDLE;
    else state <= state_next;
  end

  // Datapath: one input bit per cycle in decimal, one digit strip per cycle after
  always_ff @(posedge clk) begin
    case (state)
      C_IDLE: if (take) begin
        bin    <= num.value;
        bitcnt <= '0;
        ndig   <= NDIG_W'(DIGITS);
        rmode  <= num.radix_mode;
        zpad   <= num.zero_pad;
        width  <= num.min_width;
        if (num.radix_mode == RADIX_DEC) bcd <= '0;
        else bcd <= {{(BCD_W - VALUE_W){1'b0}}, num.value};
      end
      C_DAB: begin
        bcd    <= {bcd_adj[BCD_W-2:0], bin[VALUE_W-1]};
        bin    <= {bin[VALUE_W-2:0], 1'b0};
        bitcnt <= bitcnt + BIT_W'(1);
      end
      C_NORM: if (strip) begin
        bcd  <= {bcd[BCD_W-5:0], 4'd0};
        ndig <= ndig - NDIG_W'(1);
      end
      default: ;
    endcase
  end

  assign res_valid      = (state == C_DONE);
  assign res.digits     = bcd;
  assign res.ndig       = ndig;
  assign res.radix_mode = rmode;
  assign res.zero_pad   = zpad;
  assign res.min_width  = width;

  `UIA_ASSERT_NEXT(a_take_leaves_idle, take, state != C_IDLE)
  `UIA_ASSERT_NOW(a_ndig_nonzero, state == C_NORM || state == C_DONE,
                  ndig != '0 && ndig <= NDIG_W'(DIGITS))
  `UIA_ASSERT_NOW(a_hex_fits, state == C_DONE && rmode != RADIX_DEC,
                  ndig <= NDIG_W'(HEX_DIGS))

endmodule

@@ sv/uia_emit.sv @@
// Character emitter: padding then digits, one character per cycle into an
// output register unless chars stalls, cut at OUT_CAP. Depends on uia_pkg, uia_if, macros.
`include "uint64_to_ascii_padded_macros.svh"

module uia_emit
  import uia_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        res_valid,
  output logic        res_ready,
  input  conv_res_t   res,
  uia_out_if.source   chars
);

  typedef enum logic [2:0] {
    E_IDLE = 3'b001,
    E_PAD  = 3'b010,
    E_DIG  = 3'b100
  } emit_state_t;

  emit_state_t        state, state_next;
  logic [BCD_W-1:0]   digits;
  logic [NDIG_W-1:0]  ndig;
  logic [WIDTH_W-1:0] pad;
  logic [WIDTH_W-1:0] pad_init;
  logic [SENT_W-1:0]  sent;
  logic               lower;
  logic [7:0]         padch;
  logic [7:0]         ochar;
  logic               olast;
  logic               ovalid;
  logic               ovalid_next;
  logic               take;
  logic               fire;
  logic               at_cap;
  logic               last_next;

  assign res_ready = (state == E_IDLE);
  assign take      = res_valid && res_ready;
  assign fire      = (state != E_IDLE) && (!ovalid || chars.ready);
  assign at_cap    = (sent == SENT_W'(OUT_CAP - 1));
  assign last_next = at_cap || ((state == E_DIG) && (ndig == NDIG_W'(1)));

  // Padding needed ahead of the digits
  always_comb begin
    if (res.min_width > WIDTH_W'(res.ndig)) pad_init = res.min_width - WIDTH_W'(res.ndig);
    else pad_init = '0;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      E_IDLE: if (take) state_next = (pad_init != '0) ? E_PAD : E_DIG;
      E_PAD:  if (fire) begin
        if (at_cap) state_next = E_IDLE;
        else if (pad == WIDTH_W'(1)) state_next = E_DIG;
      end
      E_DIG:  if (fire && last_next) state_next = E_IDLE;
      default: state_next = E_IDLE;
    endcase
  end

  assign ovalid_next = fire || (ovalid && !chars.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= E_IDLE;
      ovalid <= 1'b0;
    end else begin
      state  <= state_next;
      ovalid <= ovalid_next;
    end
  end

  // Datapath: load a number, then shift one digit out per digit character
  always_ff @(posedge clk) begin
    if (take) begin
      digits <= res.digits;
      ndig   <= res.ndig;
      pad    <= pad_init;
      sent   <= '0;
      lower  <= (res.radix_mode == RADIX_LOWER);
      padch  <= res.zero_pad ? CH_ZERO : CH_SPACE;
    end else if (fire) begin
      sent  <= sent + SENT_W'(1);
      olast <= last_next;
      if (state == E_PAD) begin
        ochar <= padch;
        pad   <= pad - WIDTH_W'(1);
      end else begin
        ochar  <= digit_char(digits[BCD_W-1 -: 4], lower);
        digits <= {digits[BCD_W-5:0], 4'd0};
        ndig   <= ndig - NDIG_W'(1);
      end
    end
  end

  assign chars.valid     = ovalid;
  assign chars.out_char  = ochar;
  assign chars.last_char = olast;

  `UIA_ASSERT_NOW(a_dig_left, state == E_DIG, ndig != '0)
  `UIA_ASSERT_NOW(a_cap_bound, state != E_IDLE, sent < SENT_W'(OUT_CAP))
  `UIA_ASSERT_NEXT(a_last_ends, fire && last_next, state == E_IDLE && olast)

endmodule

@@ sv/uint64_to_ascii_padded.sv @@
// Channel   Role  Payload                                   Handshake
// num       in    value[64] radix_mode[2] zero_pad min_width[6]  valid/ready
// chars     out   out_char[8] last_char                     valid/ready
//
// Decimal: shift-and-add-3 (one input bit per cycle), then leading-zero
// strip; hex: strip only (the top four nibbles are always zero); then a
// handoff, and the converter returns to idle to accept the next number.
// Emission: one character per cycle unless chars stalls, 1..39 per
// transaction, overlapped with the next conversion.
// Synchronous active-high reset clears both state machines and the output valid.
// A stalled chars channel holds the output register and pauses emission only.
// Top level: ties the converter to the emitter. Depends on uia_pkg, uia_if,
// uia_conv and uia_emit.
module uint64_to_ascii_padded
  import uia_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  uia_in_if.sink      num,
  uia_out_if.source   chars
);

  conv_res_t res;
  logic      res_valid;
  logic      res_ready;

  uia_conv u_conv (
    .clk       (clk),
    .rst       (rst),
    .num       (num),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  uia_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .chars     (chars)
  );

endmodule
